>>> hdl/led_pattern_sequencer_assert.svh
// Assertion macros for the LED pattern sequencer controller (lps_ctrl).
// Define ASSERT_OFF to compile the checks out; no other dependencies.
`ifndef LED_PATTERN_SEQUENCER_ASSERT_SVH
`define LED_PATTERN_SEQUENCER_ASSERT_SVH

`ifndef ASSERT_OFF
// Antecedent implies consequent in the same cycle.
`define LPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("led_pattern_sequencer: assertion failed");
// Antecedent implies consequent in the next cycle.
`define LPS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("led_pattern_sequencer: assertion failed");
`else
`define LPS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LPS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hdl/lps_pkg.sv
// Package for the LED pattern sequencer: widths, codes, payload and
// control structs shared by all modules. No dependencies.
package lps_pkg;

    localparam int FULL_DUTY    = 8191;
    localparam int DUTY_W       = $clog2(FULL_DUTY + 1);
    localparam int TIME_W       = 16;
    localparam int ACC_W        = DUTY_W + TIME_W;
    localparam int BRIGHT_W     = 7;
    localparam int TIMES_W      = 15;
    localparam int PERCENT_FULL = 100;
    localparam int FADE_RESET   = 1000;
    localparam int DIV_CNT_W    = $clog2(DUTY_W + 1);

    // Brightness scaling: b * FULL_DUTY / 100 as one multiply by a rounded-up
    // reciprocal and a shift, exact for every percent below 100.
    localparam int BRIGHT_SHIFT = 27;
    localparam int SCALE_W      = BRIGHT_SHIFT + DUTY_W;
    localparam longint unsigned BRIGHT_RECIP =
        ((64'd1 << BRIGHT_SHIFT) + 64'(PERCENT_FULL) - 64'd1) / 64'(PERCENT_FULL)
        * 64'(FULL_DUTY);

    typedef enum logic [2:0] {
        CMD_TICK       = 3'd0,
        CMD_SET_BRIGHT = 3'd1,
        CMD_TURN_ON    = 3'd2,
        CMD_TURN_OFF   = 3'd3,
        CMD_BLINK      = 3'd4,
        CMD_HEARTBEAT  = 3'd5,
        CMD_FADE       = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_STEADY = 2'd0,
        MODE_BLINK  = 2'd1,
        MODE_HEART  = 2'd2,
        MODE_FADE   = 2'd3
    } mode_t;

    typedef struct packed {
        logic [2:0]          command;
        logic [BRIGHT_W-1:0] brightness;
        logic [TIMES_W-1:0]  blink_times;
        logic                blink_forever;
        logic [TIME_W-1:0]   blink_interval_ms;
        logic [TIME_W-1:0]   heartbeat_period_ms;
        logic [TIME_W-1:0]   heartbeat_pulse_ms;
    } in_item_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic [1:0]        mode;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic div_start;
        logic div_wr;
        logic out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;
        logic div_busy;
    } dp_status_t;

    // A time of zero counts as one millisecond.
    function automatic logic [TIME_W-1:0] at_least_one(input logic [TIME_W-1:0] v);
        return (v == '0) ? TIME_W'(1) : v;
    endfunction

endpackage

>>> hdl/lps_in_if.sv
// Request channel of the LED pattern sequencer: valid, ready and fields.
// Depends on lps_pkg for field widths.
interface lps_in_if;
    import lps_pkg::*;

    logic                valid;
    logic                ready;
    logic [2:0]          command;
    logic [BRIGHT_W-1:0] brightness;
    logic [TIMES_W-1:0]  blink_times;
    logic                blink_forever;
    logic [TIME_W-1:0]   blink_interval_ms;
    logic [TIME_W-1:0]   heartbeat_period_ms;
    logic [TIME_W-1:0]   heartbeat_pulse_ms;

    modport source (
        output valid, command, brightness, blink_times, blink_forever,
               blink_interval_ms, heartbeat_period_ms, heartbeat_pulse_ms,
        input  ready
    );

    modport sink (
        input  valid, command, brightness, blink_times, blink_forever,
               blink_interval_ms, heartbeat_period_ms, heartbeat_pulse_ms,
        output ready
    );
endinterface

>>> hdl/lps_out_if.sv
// Result channel of the LED pattern sequencer: valid, ready, duty and mode.
// Depends on lps_pkg for field widths.
interface lps_out_if;
    import lps_pkg::*;

    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] duty;
    logic [1:0]        mode;

    modport source (
        output valid, duty, mode,
        input  ready
    );

    modport sink (
        input  valid, duty, mode,
        output ready
    );
endinterface

>>> hdl/lps_div.sv
// Restoring divider, one quotient bit per cycle, for quotients that fit
// in DUTY_W bits. Depends on lps_pkg.
module lps_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lps_pkg::ACC_W-1:0]   dividend,
    input  logic [lps_pkg::TIME_W-1:0]  divisor,
    output logic                        busy,
    output logic [lps_pkg::DUTY_W-1:0]  quotient
);
    import lps_pkg::*;

    logic [DIV_CNT_W-1:0] count_reg, count_next;
    logic [TIME_W-1:0]    rem_reg, rem_next;
    logic [DUTY_W-1:0]    quot_reg, quot_next;
    logic [TIME_W-1:0]    dvsr_reg, dvsr_next;
    logic [TIME_W:0]      trial;
    logic                 fits;

    // One shift-and-subtract step per cycle while the count runs.
    always_comb
    begin
        count_next = count_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        dvsr_next  = dvsr_reg;
        trial      = {rem_reg, quot_reg[DUTY_W-1]};
        fits       = (trial >= {1'b0, dvsr_reg});
        if (start)
        begin
            // The upper bits are below the divisor since the quotient fits.
            rem_next   = dividend[ACC_W-1:DUTY_W];
            quot_next  = dividend[DUTY_W-1:0];
            dvsr_next  = divisor;
            count_next = DIV_CNT_W'(DUTY_W);
        end
        else if (count_reg != '0)
        begin
            rem_next   = fits ? TIME_W'(trial - {1'b0, dvsr_reg}) : trial[TIME_W-1:0];
            quot_next  = {quot_reg[DUTY_W-2:0], fits};
            count_next = count_reg - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Operand registers carry no reset.
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dvsr_reg <= dvsr_next;
    end

    assign busy     = (count_reg != '0);
    assign quotient = quot_reg;
endmodule

>>> hdl/lps_datapath.sv
// Datapath of the LED pattern sequencer: pattern state, fade register,
// ramp and brightness arithmetic, and the result register. Uses lps_pkg, lps_div.
module lps_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lps_pkg::dp_cmd_t            cmd,
    output lps_pkg::dp_status_t         status,
    input  lps_pkg::in_item_t           item,
    input  logic                        cfg_we,
    input  logic [lps_pkg::TIME_W-1:0]  cfg_data,
    output logic [lps_pkg::TIME_W-1:0]  fade_time,
    output lps_pkg::out_item_t          result
);
    import lps_pkg::*;

    logic [TIME_W-1:0]   fade_time_reg, fade_time_next;
    logic [DUTY_W-1:0]   level_duty_reg, level_duty_next;
    logic [DUTY_W-1:0]   out_duty_reg, out_duty_next;
    mode_t               pattern_mode_reg, pattern_mode_next;
    logic [TIME_W-1:0]   toggle_count_reg, toggle_count_next;
    logic                forever_flag_reg, forever_flag_next;
    logic [TIME_W-1:0]   period_len_reg, period_len_next;
    logic [TIME_W-1:0]   period_left_reg, period_left_next;
    logic [TIME_W-1:0]   pulse_len_reg, pulse_len_next;
    logic [TIME_W-1:0]   pulse_left_reg, pulse_left_next;
    logic                pulse_active_reg, pulse_active_next;
    logic                ramp_rising_reg, ramp_rising_next;
    logic [DUTY_W-1:0]   ramp_start_reg, ramp_start_next;
    logic [TIME_W-1:0]   ramp_elapsed_reg, ramp_elapsed_next;
    out_item_t           result_reg;

    logic [TIME_W-1:0]   t_eff;
    logic [TIME_W-1:0]   elapsed_inc;
    logic                fade_end;
    logic [TIME_W-1:0]   period_dec;
    logic [TIME_W-1:0]   pulse_dec;
    logic [TIME_W-1:0]   toggle_dec;
    logic                bright_full;
    logic [SCALE_W-1:0]  bright_scaled;
    logic [DUTY_W-1:0]   ramp_target;
    logic [DUTY_W-1:0]   mul_a;
    logic [TIME_W-1:0]   mul_b;
    logic [ACC_W-1:0]    mul_c;
    logic [ACC_W-1:0]    product;
    logic [TIME_W-1:0]   div_divisor;
    logic                div_busy;
    logic [DUTY_W-1:0]   div_quotient;

    // Shared terms of the tick and command updates.
    assign t_eff       = at_least_one(fade_time_reg);
    assign elapsed_inc = ramp_elapsed_reg + TIME_W'(1);
    assign fade_end    = (elapsed_inc >= t_eff) || (elapsed_inc == '0);
    assign period_dec  = period_left_reg - TIME_W'(1);
    assign pulse_dec   = pulse_left_reg - TIME_W'(1);
    assign toggle_dec  = toggle_count_reg - TIME_W'(1);
    assign bright_full = (item.brightness >= BRIGHT_W'(PERCENT_FULL));
    assign ramp_target = ramp_rising_reg ? DUTY_W'(FULL_DUTY) : '0;

    // Brightness percent scaled to a duty by the reciprocal of 100.
    assign bright_scaled = SCALE_W'(item.brightness) * SCALE_W'(BRIGHT_RECIP);

    // Only an interior fade step needs the divider.
    assign status.need_div =
        (cmd_t'(item.command) == CMD_TICK) && (pattern_mode_reg == MODE_FADE) && !fade_end;
    assign status.div_busy = div_busy;

    // State update on an accepted transaction or a fade time write, and quotient write-back.
    always_comb
    begin
        fade_time_next    = fade_time_reg;
        level_duty_next   = level_duty_reg;
        out_duty_next     = out_duty_reg;
        pattern_mode_next = pattern_mode_reg;
        toggle_count_next = toggle_count_reg;
        forever_flag_next = forever_flag_reg;
        period_len_next   = period_len_reg;
        period_left_next  = period_left_reg;
        pulse_len_next    = pulse_len_reg;
        pulse_left_next   = pulse_left_reg;
        pulse_active_next = pulse_active_reg;
        ramp_rising_next  = ramp_rising_reg;
        ramp_start_next   = ramp_start_reg;
        ramp_elapsed_next = ramp_elapsed_reg;

        if (cfg_we)
        begin
            fade_time_next = cfg_data;
        end

        if (cmd.accept)
        begin
            case (cmd_t'(item.command))
                CMD_TICK:
                begin
                    case (pattern_mode_reg)
                        MODE_BLINK:
                        begin
                            if (forever_flag_reg || (toggle_count_reg != '0))
                            begin
                                if (period_dec != '0)
                                begin
                                    period_left_next = period_dec;
                                end
                                else
                                begin
                                    period_left_next  = period_len_reg;
                                    toggle_count_next = toggle_dec;
                                    if (toggle_dec[0])
                                    begin
                                        out_duty_next = level_duty_reg;
                                    end
                                    else
                                    begin
                                        out_duty_next = '0;
                                        if ((toggle_dec == '0) && !forever_flag_reg)
                                        begin
                                            pattern_mode_next = MODE_STEADY;
                                        end
                                    end
                                end
                            end
                        end
                        MODE_HEART:
                        begin
                            // A running pulse counts down before the period.
                            if (pulse_active_reg)
                            begin
                                pulse_left_next = pulse_dec;
                                if (pulse_dec == '0)
                                begin
                                    out_duty_next     = '0;
                                    pulse_active_next = 1'b0;
                                end
                            end
                            if (period_dec == '0)
                            begin
                                period_left_next  = period_len_reg;
                                out_duty_next     = level_duty_reg;
                                pulse_left_next   = pulse_len_reg;
                                pulse_active_next = 1'b1;
                            end
                            else
                            begin
                                period_left_next = period_dec;
                            end
                        end
                        MODE_FADE:
                        begin
                            if (fade_end)
                            begin
                                out_duty_next     = ramp_target;
                                ramp_start_next   = ramp_target;
                                ramp_rising_next  = !ramp_rising_reg;
                                ramp_elapsed_next = '0;
                            end
                            else
                            begin
                                // The interpolated duty comes from the divider.
                                ramp_elapsed_next = elapsed_inc;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                CMD_SET_BRIGHT:
                begin
                    if (bright_full)
                    begin
                        level_duty_next = DUTY_W'(FULL_DUTY);
                    end
                    else
                    begin
                        level_duty_next = bright_scaled[SCALE_W-1:BRIGHT_SHIFT];
                    end
                end
                CMD_TURN_ON:
                begin
                    pattern_mode_next = MODE_STEADY;
                    pulse_active_next = 1'b0;
                    out_duty_next     = level_duty_reg;
                end
                CMD_TURN_OFF:
                begin
                    pattern_mode_next = MODE_STEADY;
                    pulse_active_next = 1'b0;
                    out_duty_next     = '0;
                end
                CMD_BLINK:
                begin
                    pulse_active_next = 1'b0;
                    forever_flag_next = item.blink_forever;
                    toggle_count_next = {item.blink_times, 1'b0};
                    period_len_next   = at_least_one(item.blink_interval_ms);
                    period_left_next  = at_least_one(item.blink_interval_ms);
                    if (!item.blink_forever && (item.blink_times == '0))
                    begin
                        pattern_mode_next = MODE_STEADY;
                    end
                    else
                    begin
                        pattern_mode_next = MODE_BLINK;
                    end
                end
                CMD_HEARTBEAT:
                begin
                    pattern_mode_next = MODE_HEART;
                    period_len_next   = at_least_one(item.heartbeat_period_ms);
                    period_left_next  = at_least_one(item.heartbeat_period_ms);
                    pulse_len_next    = at_least_one(item.heartbeat_pulse_ms);
                    pulse_left_next   = '0;
                    pulse_active_next = 1'b0;
                    out_duty_next     = '0;
                end
                CMD_FADE:
                begin
                    pattern_mode_next = MODE_FADE;
                    pulse_active_next = 1'b0;
                    ramp_rising_next  = 1'b1;
                    ramp_start_next   = out_duty_reg;
                    ramp_elapsed_next = '0;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.div_wr)
        begin
            out_duty_next = div_quotient;
        end
    end

    // Multiply stage feeding the divider's operand registers:
    // the fade gives (start * (T - e) + target * e) / T.
    always_comb
    begin
        mul_a       = ramp_start_reg;
        mul_b       = t_eff - ramp_elapsed_reg;
        mul_c       = ramp_rising_reg ? ACC_W'(ramp_elapsed_reg) * ACC_W'(FULL_DUTY) : '0;
        div_divisor = t_eff;
        product     = ACC_W'(mul_a) * ACC_W'(mul_b) + mul_c;
    end

    lps_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (product),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_time_reg    <= TIME_W'(FADE_RESET);
            level_duty_reg   <= '0;
            out_duty_reg     <= '0;
            pattern_mode_reg <= MODE_STEADY;
            toggle_count_reg <= '0;
            forever_flag_reg <= 1'b0;
            period_len_reg   <= '0;
            period_left_reg  <= '0;
            pulse_len_reg    <= '0;
            pulse_left_reg   <= '0;
            pulse_active_reg <= 1'b0;
            ramp_rising_reg  <= 1'b0;
            ramp_start_reg   <= '0;
            ramp_elapsed_reg <= '0;
        end
        else
        begin
            fade_time_reg    <= fade_time_next;
            level_duty_reg   <= level_duty_next;
            out_duty_reg     <= out_duty_next;
            pattern_mode_reg <= pattern_mode_next;
            toggle_count_reg <= toggle_count_next;
            forever_flag_reg <= forever_flag_next;
            period_len_reg   <= period_len_next;
            period_left_reg  <= period_left_next;
            pulse_len_reg    <= pulse_len_next;
            pulse_left_reg   <= pulse_left_next;
            pulse_active_reg <= pulse_active_next;
            ramp_rising_reg  <= ramp_rising_next;
            ramp_start_reg   <= ramp_start_next;
            ramp_elapsed_reg <= ramp_elapsed_next;
        end
    end

    // Payload register: the result.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            result_reg.duty <= out_duty_reg;
            result_reg.mode <= pattern_mode_reg;
        end
    end

    assign result    = result_reg;
    assign fade_time = fade_time_reg;
endmodule

>>> hdl/lps_ctrl.sv
// Controller of the LED pattern sequencer: sequences accept, multiply,
// divide and result load, and holds the result valid flag. Uses lps_pkg.
`include "led_pattern_sequencer_assert.svh"

module lps_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    output logic                 res_valid,
    input  logic                 res_ready,
    input  lps_pkg::dp_status_t  status,
    output lps_pkg::dp_cmd_t     cmd
);
    import lps_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   res_valid_reg, res_valid_next;
    logic   slot_free;

    assign slot_free = !res_valid_reg || res_ready;

    // Next state and datapath commands.
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        res_valid_next = res_valid_reg && !res_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.need_div ? S_LOAD : S_OUT;
                end
            end
            S_LOAD:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (!status.div_busy)
                begin
                    cmd.div_wr = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;

    // A transaction that needs the divider goes through the multiply step.
    `LPS_ASSERT_NXT(a_div_path, clk, rst_n, (state_reg == S_IDLE) && req_valid && status.need_div, state_reg == S_LOAD)
    // The divider is running right after it is started.
    `LPS_ASSERT_NXT(a_div_started, clk, rst_n, state_reg == S_LOAD, status.div_busy)
    // A result is only loaded when the output register can take it.
    `LPS_ASSERT_IMP(a_slot_free, clk, rst_n, cmd.out_load, !res_valid_reg || res_ready)
    // No request is taken while a division is in flight.
    `LPS_ASSERT_IMP(a_busy_no_accept, clk, rst_n, status.div_busy, !req_ready)
endmodule

>>> hdl/led_pattern_sequencer.sv
// LED pattern sequencer top level: APB register port, request and result
// channels, controller and datapath. Uses lps_pkg, lps_in_if, lps_out_if.
//
// Usage: each request transaction carries one command (1 ms tick,
// set_brightness, turn_on, turn_off, blink, heartbeat, fade) and yields
// exactly one result transaction with the LED duty and pattern mode after it.
// The result is loaded into the output register from the S_OUT state; a
// fade tick inside a ramp passes first through S_LOAD and S_DIV, where a
// restoring divider produces one quotient bit per cycle.
// One request is processed at a time: a new request is accepted only after
// the controller has loaded the previous result and returned to idle.
// The result sits in an output register; a new request is accepted while it
// waits, and a stalled receiver only holds the next result back until the
// register is taken.
// The fade time register (byte address 0, reset 1000 ms) must be written
// over APB only while the block is idle (not enforced); pready is always high.
// Reset clears all pattern state to a dark steady LED; no clearing pass.
module led_pattern_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    lps_in_if.sink      request,
    lps_out_if.source   result
);
    import lps_pkg::*;

    dp_cmd_t           cmd;
    dp_status_t        status;
    in_item_t          item;
    out_item_t         res_item;
    logic              cfg_we;
    logic [TIME_W-1:0] fade_time;

    // Register decode: only index 0 exists, selected by address bit 2.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {{(32 - TIME_W){1'b0}}, fade_time};

    // Request fields gathered into one item.
    assign item.command             = request.command;
    assign item.brightness          = request.brightness;
    assign item.blink_times         = request.blink_times;
    assign item.blink_forever       = request.blink_forever;
    assign item.blink_interval_ms   = request.blink_interval_ms;
    assign item.heartbeat_period_ms = request.heartbeat_period_ms;
    assign item.heartbeat_pulse_ms  = request.heartbeat_pulse_ms;

    lps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_ready (request.ready),
        .res_valid (result.valid),
        .res_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    lps_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_data  (pwdata[TIME_W-1:0]),
        .fade_time (fade_time),
        .result    (res_item)
    );

    assign result.duty = res_item.duty;
    assign result.mode = res_item.mode;
endmodule
